// ===== hw/rtl/sewa_pkg.sv =====
package sewa_pkg;

  localparam int CAPACITY     = 64;
  localparam int NODE_ID_BITS = 16;
  localparam int WT_W         = 32;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int KEY_W        = 2 * NODE_ID_BITS;

  typedef logic [NODE_ID_BITS-1:0] node_id_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCUM  = 2'd0,
    ST_INSERT = 2'd1,
    ST_FULL   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_SEARCH,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } state_t;

  typedef struct packed {
    node_id_t          src;
    node_id_t          tgt;
    logic [WT_W-1:0]   wt;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } mem_req_t;

  typedef struct packed {
    op_t             op;
    node_id_t        src;
    node_id_t        tgt;
    logic [WT_W-1:0] inc;
    logic [5:0]      rank;
  } item_t;

  typedef struct packed {
    status_t         status;
    node_id_t        src;
    node_id_t        tgt;
    logic [WT_W-1:0] wt;
    count_t          count;
  } result_t;

endpackage

// ===== hw/rtl/sewa_table.sv =====
module sewa_table import sewa_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [CAPACITY];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== hw/rtl/sewa_seq.sv =====
module sewa_seq import sewa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  item_t    item_in,
  input  entry_t   rdata,
  input  logic     res_take,
  output logic     busy,
  output logic     res_valid,
  output result_t  res,
  output mem_req_t mem_req
);

  state_t  state, state_next;
  item_t   item;
  count_t  p, p_next;
  count_t  k, k_next;
  count_t  count, count_next;
  result_t res_next;

  logic [KEY_W-1:0] key, rkey;
  logic in_range, key_lt, key_eq, full;
  logic [WT_W-1:0] wt_sum;

  assign key      = {item.src, item.tgt};
  assign rkey     = {rdata.src, rdata.tgt};
  assign in_range = (p < count);
  assign key_lt   = (rkey < key);
  assign key_eq   = (rkey == key);
  assign full     = (count == count_t'(CAPACITY));
  assign wt_sum   = rdata.wt + item.inc;

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_START;
      S_START:  state_next = (item.op == OP_READ) ? S_READ : S_SEARCH;
      S_READ:   state_next = S_DONE;
      S_SEARCH: begin
        if (in_range && key_lt) begin
          state_next = S_SEARCH;
        end else if ((in_range && key_eq) || full) begin
          state_next = S_DONE;
        end else if (count > p) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_SHIFT:  if (k <= p + count_t'(1)) state_next = S_INSERT;
      S_INSERT: state_next = S_DONE;
      S_DONE:   if (res_take) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_req       = '0;
    mem_req.raddr = p[ADDR_W-1:0];
    p_next        = p;
    k_next        = k;
    count_next    = count;
    res_next      = res;
    case (state)
      S_IDLE: begin
        p_next = '0;
      end
      S_START: begin
        mem_req.raddr = (item.op == OP_READ) ? ADDR_W'(item.rank) : '0;
      end
      S_READ: begin
        res_next.count = count;
        if (item.rank >= count) begin
          res_next.status = ST_RANGE;
          res_next.src    = '0;
          res_next.tgt    = '0;
          res_next.wt     = '0;
        end else begin
          res_next.status = ST_ACCUM;
          res_next.src    = rdata.src;
          res_next.tgt    = rdata.tgt;
          res_next.wt     = rdata.wt;
        end
      end
      S_SEARCH: begin
        res_next.src   = item.src;
        res_next.tgt   = item.tgt;
        res_next.count = count;
        if (in_range && key_lt) begin
          p_next        = p + count_t'(1);
          mem_req.raddr = p_next[ADDR_W-1:0];
        end else if (in_range && key_eq) begin
          mem_req.we       = 1'b1;
          mem_req.waddr    = p[ADDR_W-1:0];
          mem_req.wdata    = '{src: rdata.src, tgt: rdata.tgt, wt: wt_sum};
          res_next.status  = ST_ACCUM;
          res_next.wt      = wt_sum;
        end else if (full) begin
          res_next.status = ST_FULL;
          res_next.wt     = '0;
        end else if (count > p) begin
          // start moving entries up from the top
          k_next        = count;
          mem_req.raddr = addr_t'(count - count_t'(1));
        end
      end
      S_SHIFT: begin
        // rdata holds entry k-1, copied into slot k
        mem_req.we    = 1'b1;
        mem_req.waddr = k[ADDR_W-1:0];
        mem_req.wdata = rdata;
        mem_req.raddr = addr_t'(k - count_t'(2));
        k_next        = k - count_t'(1);
      end
      S_INSERT: begin
        mem_req.we      = 1'b1;
        mem_req.waddr   = p[ADDR_W-1:0];
        mem_req.wdata   = '{src: item.src, tgt: item.tgt, wt: item.inc};
        count_next      = count + count_t'(1);
        res_next.status = ST_INSERT;
        res_next.wt     = item.inc;
        res_next.count  = count + count_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    if (start && state == S_IDLE) begin
      item <= item_in;
    end
    p   <= p_next;
    k   <= k_next;
    res <= res_next;
  end

endmodule

// ===== hw/rtl/sorted_edge_weight_accumulator_core.sv =====
// channel | signals                                          | transfer when
// input   | operation source_node target_node                |
//         | weight_increment rank_index                      | in_valid & in_ready
// output  | status out_source out_target out_weight          |
//         | entry_count                                      | out_valid & out_ready
//
// an add walks the sorted table one entry per cycle, then moves later entries
// up one slot per cycle; a hit adds to the weight in place, an insert writes
// the new pair into the freed slot; a read fetches one entry by rank, all through
// the single table read port. reset empties the table at once (count to zero)
// the result sits in an output register, so a stalled output still lets the
// next item be taken; the sequencer waits only if that register is still full
module sorted_edge_weight_accumulator_core import sewa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] source_node,
  input  logic [15:0] target_node,
  input  logic [31:0] weight_increment,
  input  logic [5:0]  rank_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] out_source,
  output logic [15:0] out_target,
  output logic [31:0] out_weight,
  output logic [6:0]  entry_count
);

  logic     busy;
  logic     start;
  logic     res_valid;
  logic     res_take;
  item_t    item_in;
  result_t  res;
  mem_req_t mem_req;
  entry_t   rdata;

  // one item at a time: ready while the sequencer is idle
  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  // node ids are taken in their low bits
  assign item_in.op   = op_t'(operation);
  assign item_in.src  = node_id_t'(source_node);
  assign item_in.tgt  = node_id_t'(target_node);
  assign item_in.inc  = weight_increment;
  assign item_in.rank = rank_index;

  // the output register takes a result when empty or being drained
  assign res_take = !out_valid || out_ready;

  sewa_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item_in   (item_in),
    .rdata     (rdata),
    .res_take  (res_take),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req)
  );

  sewa_table u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
    if (res_take && res_valid) begin
      status      <= res.status;
      out_source  <= 16'(res.src);
      out_target  <= 16'(res.tgt);
      out_weight  <= res.wt;
      entry_count <= 7'(res.count);
    end
  end

  // the table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= 7'(CAPACITY)))
    else $error("entry count above capacity");

  // a dropped pair is only reported with a full table
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (entry_count == 7'(CAPACITY)))
    else $error("drop reported with room left");

  // an out of range read carries zero payload
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_RANGE) |->
      (out_source == 16'd0 && out_target == 16'd0 && out_weight == 32'd0))
    else $error("out of range read with nonzero payload");

  // after a transfer in, the block is busy with that item
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting an item");

endmodule
